// ===== rtl/ufcl_pkg.sv =====
// Shared types and constants for the serial firmware chunk loader.
`timescale 1ns / 1ps

package ufcl_pkg;

  // Result kinds
  localparam logic [1:0] KIND_WORD    = 2'd0;
  localparam logic [1:0] KIND_CHUNK   = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;
  localparam logic [1:0] KIND_TRAILER = 2'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QLEVEL_W    = $clog2(QUEUE_DEPTH + 1);

  // Everything one byte produces: an optional word write and an optional marker.
  typedef struct packed {
    logic        has_word;
    logic        tail_valid;
    logic [1:0]  tail_kind;
    logic        tail_ok;
    logic [31:0] word_addr;
    logic [31:0] word_data;
  } rec_t;

endpackage

// ===== rtl/ufcl_core.sv =====
// Byte stage register, command parser, word packer and trailer check.
`timescale 1ns / 1ps

module ufcl_core import ufcl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        byte_valid,
  input  logic [7:0]  byte_in,
  output logic        busy,
  output logic        push,
  output rec_t        rec
);

  typedef enum logic [1:0] {
    PH_COMMAND,
    PH_RECEIVE,
    PH_TRAILER,
    PH_FINISHED
  } phase_t;

  localparam logic [31:0] LOAD_BASE_RESET = 32'hFFDC_0000;
  localparam logic [31:0] CHUNK_RESET     = 32'd4096;
  localparam logic [7:0]  CH_NUL          = 8'h00;
  localparam logic [7:0]  CH_SPACE        = 8'h20;
  localparam logic [7:0]  CH_PLUS         = 8'h2B;
  localparam logic [7:0]  CH_MINUS        = 8'h2D;
  localparam logic [2:0]  TRAILER_LEN     = 3'd7;
  localparam logic [1:0]  MODE_LEAD       = 2'd0;
  localparam logic [1:0]  MODE_DIGITS     = 2'd1;
  localparam logic [1:0]  MODE_STOP       = 2'd2;

  function automatic logic [7:0] trailer_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h50; // P
      3'd1:    c = 8'h4D; // M
      3'd2:    c = 8'h55; // U
      3'd3:    c = 8'h5F; // _
      3'd4:    c = 8'h44; // D
      3'd5:    c = 8'h4F; // O
      3'd6:    c = 8'h4E; // N
      default: c = 8'h45; // E
    endcase
    return c;
  endfunction

  logic        stage_valid;
  logic [7:0]  stage_byte;

  phase_t      phase, phase_next;
  logic [31:0] load_base;
  logic [3:0]  field_number, field_number_next;
  logic [31:0] chunk_size, chunk_size_next;
  logic [31:0] total_size, total_size_next;
  logic [31:0] bytes_received, bytes_received_next;
  logic [31:0] chunk_fill, chunk_fill_next;
  logic [31:0] chunk_offset, chunk_offset_next;
  logic [23:0] word_assembly, word_assembly_next;
  logic [2:0]  trailer_position, trailer_position_next;
  logic        trailer_match, trailer_match_next;
  logic [1:0]  parse_mode, parse_mode_next;
  logic        parse_neg, parse_neg_next;

  logic [31:0] fval, fval_closed, fval_digit;
  logic [35:0] prod;
  logic [3:0]  fn_inc;
  logic [31:0] fill_inc, br_inc;
  logic [1:0]  idx;
  logic        field_open;

  assign busy = stage_valid;

  always_comb begin
    phase_next            = phase;
    field_number_next     = field_number;
    chunk_size_next       = chunk_size;
    total_size_next       = total_size;
    bytes_received_next   = bytes_received;
    chunk_fill_next       = chunk_fill;
    chunk_offset_next     = chunk_offset;
    word_assembly_next    = word_assembly;
    trailer_position_next = trailer_position;
    trailer_match_next    = trailer_match;
    parse_mode_next       = parse_mode;
    parse_neg_next        = parse_neg;
    rec                   = '0;

    field_open  = (field_number == 4'd1) || (field_number == 4'd2);
    fval        = (field_number == 4'd1) ? chunk_size : total_size;
    fval_closed = parse_neg ? (32'd0 - fval) : fval;
    // value * 10 + digit, saturating at 32 bits
    prod        = {1'b0, fval, 3'b000} + {3'b000, fval, 1'b0} + {32'd0, stage_byte[3:0]};
    fval_digit  = (prod[35:32] != 4'd0) ? 32'hFFFF_FFFF : prod[31:0];
    fn_inc      = (field_number != 4'd15) ? (field_number + 4'd1) : field_number;
    idx         = chunk_fill[1:0];
    fill_inc    = chunk_fill + 32'd1;
    br_inc      = bytes_received + 32'd1;

    if (stage_valid) begin
      case (phase)
        PH_COMMAND: begin
          if (stage_byte == CH_NUL) begin
            if (field_number == 4'd0) begin
              chunk_size_next = 32'd0;
              total_size_next = 32'd0;
            end else if (field_number == 4'd1) begin
              chunk_size_next = fval_closed;
              total_size_next = 32'd0;
            end else if (field_number == 4'd2) begin
              total_size_next = fval_closed;
            end
            field_number_next   = 4'd0;
            parse_mode_next     = MODE_LEAD;
            parse_neg_next      = 1'b0;
            bytes_received_next = 32'd0;
            chunk_fill_next     = 32'd0;
            chunk_offset_next   = 32'd0;
            word_assembly_next  = 24'd0;
            phase_next          = PH_RECEIVE;
          end else if (stage_byte == CH_SPACE) begin
            if (field_number == 4'd1) chunk_size_next = fval_closed;
            if (field_number == 4'd2) total_size_next = fval_closed;
            field_number_next = fn_inc;
            parse_mode_next   = MODE_LEAD;
            parse_neg_next    = 1'b0;
            if (fn_inc == 4'd1) chunk_size_next = 32'd0;
            if (fn_inc == 4'd2) total_size_next = 32'd0;
          end else if (field_open && (parse_mode != MODE_STOP)) begin
            if (stage_byte inside {[8'h30:8'h39]}) begin
              if (field_number == 4'd1) chunk_size_next = fval_digit;
              else                      total_size_next = fval_digit;
              parse_mode_next = MODE_DIGITS;
            end else if ((parse_mode == MODE_LEAD) && (stage_byte inside {[8'h09:8'h0D]})) begin
              parse_mode_next = MODE_LEAD;
            end else if ((parse_mode == MODE_LEAD) &&
                         (stage_byte inside {CH_PLUS, CH_MINUS})) begin
              if (stage_byte == CH_MINUS) parse_neg_next = 1'b1;
              parse_mode_next = MODE_DIGITS;
            end else begin
              parse_mode_next = MODE_STOP;
            end
          end
        end
        PH_RECEIVE: begin
          if (idx == 2'd3) begin
            rec.has_word       = 1'b1;
            rec.word_data      = {stage_byte, word_assembly};
            rec.word_addr      = load_base + chunk_offset + (chunk_fill - 32'd3);
            word_assembly_next = 24'd0;
          end else begin
            word_assembly_next = word_assembly | ({16'd0, stage_byte} << {idx, 3'b000});
          end
          chunk_fill_next     = fill_inc;
          bytes_received_next = br_inc;
          if (br_inc == total_size) begin
            rec.tail_valid        = 1'b1;
            rec.tail_kind         = KIND_END;
            chunk_fill_next       = 32'd0;
            word_assembly_next    = 24'd0;
            trailer_position_next = 3'd0;
            trailer_match_next    = 1'b1;
            phase_next            = PH_TRAILER;
          end else if (fill_inc == chunk_size) begin
            rec.tail_valid     = 1'b1;
            rec.tail_kind      = KIND_CHUNK;
            chunk_offset_next  = chunk_offset + chunk_size;
            chunk_fill_next    = 32'd0;
            word_assembly_next = 24'd0;
          end
        end
        PH_TRAILER: begin
          if (trailer_position < TRAILER_LEN) begin
            if (stage_byte != trailer_char(trailer_position)) trailer_match_next = 1'b0;
            trailer_position_next = trailer_position + 3'd1;
          end
          if (stage_byte == CH_NUL) begin
            rec.tail_valid = 1'b1;
            rec.tail_kind  = KIND_TRAILER;
            rec.tail_ok    = trailer_match_next;
            phase_next     = PH_FINISHED;
          end
        end
        default: begin
          // finished: input is dropped
        end
      endcase
    end

    push = stage_valid && (rec.has_word || rec.tail_valid);
  end

  always_ff @(posedge clk) begin
    if (byte_valid) stage_byte <= byte_in;
    if (rst) begin
      stage_valid      <= 1'b0;
      load_base        <= LOAD_BASE_RESET;
      phase            <= PH_COMMAND;
      field_number     <= 4'd0;
      chunk_size       <= CHUNK_RESET;
      total_size       <= 32'd0;
      bytes_received   <= 32'd0;
      chunk_fill       <= 32'd0;
      chunk_offset     <= 32'd0;
      word_assembly    <= 24'd0;
      trailer_position <= 3'd0;
      trailer_match    <= 1'b1;
      parse_mode       <= MODE_LEAD;
      parse_neg        <= 1'b0;
    end else begin
      stage_valid      <= byte_valid;
      if (cfg_we) load_base <= cfg_data;
      phase            <= phase_next;
      field_number     <= field_number_next;
      chunk_size       <= chunk_size_next;
      total_size       <= total_size_next;
      bytes_received   <= bytes_received_next;
      chunk_fill       <= chunk_fill_next;
      chunk_offset     <= chunk_offset_next;
      word_assembly    <= word_assembly_next;
      trailer_position <= trailer_position_next;
      trailer_match    <= trailer_match_next;
      parse_mode       <= parse_mode_next;
      parse_neg        <= parse_neg_next;
    end
  end

  a_finished_sticks: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_FINISHED) |=> (phase == PH_FINISHED))
    else $error("loader left finished phase");

  a_trailer_alone: assert property (@(posedge clk) disable iff (rst)
    (push && rec.tail_valid && (rec.tail_kind == KIND_TRAILER)) |-> !rec.has_word)
    else $error("trailer result paired with word write");

endmodule

// ===== rtl/ufcl_out_queue.sv =====
// Result queue: holds per-byte records and plays them out one result per request.
`timescale 1ns / 1ps

module ufcl_out_queue import ufcl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rec_t                push_rec,
  output logic [QLEVEL_W-1:0] level,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [31:0]         out_addr,
  output logic [31:0]         out_data,
  output logic                out_ok,
  output logic                out_last
);

  rec_t              q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic              half;
  rec_t              head;
  logic              emit_word;
  logic              pop;

  assign head      = q[rd_ptr];
  // half set: the word of the head record is gone, its marker is next
  assign emit_word = head.has_word && !half;
  assign out_valid = (level != '0);
  assign out_kind  = emit_word ? KIND_WORD : head.tail_kind;
  assign out_addr  = emit_word ? head.word_addr : 32'd0;
  assign out_data  = emit_word ? head.word_data : 32'd0;
  assign out_ok    = emit_word ? 1'b0 : head.tail_ok;
  assign out_last  = !(emit_word && head.tail_valid);
  assign pop       = out_valid && out_ready && out_last;

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
      half   <= 1'b0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   level <= level + QLEVEL_W'(1);
        2'b01:   level <= level - QLEVEL_W'(1);
        default: level <= level;
      endcase
      if (out_valid && out_ready) half <= !out_last;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    level <= QLEVEL_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_half_pair: assert property (@(posedge clk) disable iff (rst)
    half |-> (out_valid && head.has_word && head.tail_valid))
    else $error("split record without word and marker");

endmodule

// ===== rtl/uart_firmware_chunk_loader.sv =====
// Top level of the serial firmware chunk loader.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    s_tdata[7:0] rx_byte
//  m_*       out  m_tvalid/m_tready    m_tdata addr/data/ok, m_tuser kind, m_tlast
//  cfg_*     in   cfg_valid/cfg_ready  cfg_data load_base
//
// One byte is taken per cycle while s_tready is high; results leave via the queue.
// A byte that writes a word and also closes a chunk or the download gives two
// results, handed out one per output transfer; a 4-record queue absorbs these.
// s_tready drops when queued records plus the byte in the stage register reach 4.
// Reset is synchronous and immediate: no clearing pass. cfg_ready is always high.
`timescale 1ns / 1ps

module uart_firmware_chunk_loader import ufcl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [31:0] write_address, [63:32] write_data,
                                 // [64] trailer_ok, [71:65] zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,   // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data   // load_base
);

  logic                busy;
  logic                push;
  rec_t                rec;
  logic [QLEVEL_W-1:0] level;
  logic [QLEVEL_W-1:0] pending;
  logic [31:0]         out_addr;
  logic [31:0]         out_data;
  logic                out_ok;

  assign pending   = level + QLEVEL_W'(busy);
  assign s_tready  = (pending < QLEVEL_W'(QUEUE_DEPTH));
  assign cfg_ready = 1'b1;

  ufcl_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .byte_valid (s_tvalid && s_tready),
    .byte_in    (s_tdata),
    .busy       (busy),
    .push       (push),
    .rec        (rec)
  );

  ufcl_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (rec),
    .level     (level),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_addr  (out_addr),
    .out_data  (out_data),
    .out_ok    (out_ok),
    .out_last  (m_tlast)
  );

  assign m_tdata = {7'd0, out_ok, out_data, out_addr};

endmodule
